@@ rtl/pcc_pkg.sv @@
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types and constants for the point-capsule collision test: item
// structs, register indexes and the classification flags between stages.
// ----------------------------------------------------------------------------
package pcc_pkg;

	// Coordinate width of the item fields and the default datapath width.
	localparam int PCC_COORD_W = 16;

	// Width of the configuration register index.
	localparam int PCC_CFG_IDX_W = 3;

	typedef enum logic [PCC_CFG_IDX_W-1:0] {
		PCC_REG_BASE_X = 3'd0,
		PCC_REG_BASE_Y = 3'd1,
		PCC_REG_BASE_Z = 3'd2,
		PCC_REG_TIP_X  = 3'd3,
		PCC_REG_TIP_Y  = 3'd4,
		PCC_REG_TIP_Z  = 3'd5,
		PCC_REG_RADIUS = 3'd6
	} pcc_reg_t;

	typedef struct packed {
		logic signed [PCC_COORD_W-1:0] point_x;
		logic signed [PCC_COORD_W-1:0] point_y;
		logic signed [PCC_COORD_W-1:0] point_z;
		logic                          is_root;
	} pcc_in_t;

	typedef struct packed {
		logic inside_res;
		logic stop_point;
	} pcc_out_t;

	// Outcome of the end and near tests; decided is low when only the wide
	// product comparison can settle the item.
	typedef struct packed {
		logic decided;
		logic early_inside;
		logic is_root;
	} pcc_class_t;

endpackage

@@ rtl/pcc_dots.sv @@
// ----------------------------------------------------------------------------
// pcc_dots
// Three pipeline stages: difference vectors, per-axis products, and the
// dot-product sums |w|^2, |d|^2, |v|^2 and w.d.
// ----------------------------------------------------------------------------
module pcc_dots
	import pcc_pkg::*;
#(
	parameter int COORD_WIDTH = PCC_COORD_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] point_z,
	input  logic                          is_root,
	input  logic signed [COORD_WIDTH-1:0] base_x,
	input  logic signed [COORD_WIDTH-1:0] base_y,
	input  logic signed [COORD_WIDTH-1:0] base_z,
	input  logic signed [COORD_WIDTH-1:0] tip_x,
	input  logic signed [COORD_WIDTH-1:0] tip_y,
	input  logic signed [COORD_WIDTH-1:0] tip_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2*COORD_WIDTH+1:0]      ww,
	output logic [2*COORD_WIDTH+1:0]      ll,
	output logic [2*COORD_WIDTH+1:0]      vv,
	output logic signed [2*COORD_WIDTH+2:0] ss,
	output logic                          root
);

	localparam int DW = COORD_WIDTH + 1;     // difference width
	localparam int SQW = 2 * COORD_WIDTH + 1; // unsigned square width
	localparam int KW = 2 * COORD_WIDTH + 2;  // sum of three squares

	logic signed [COORD_WIDTH-1:0] p [3];
	logic signed [COORD_WIDTH-1:0] b [3];
	logic signed [COORD_WIDTH-1:0] t [3];

	logic v_s1, v_s2, v_s3;
	logic adv_s1, adv_s2, adv_s3;

	logic signed [DW-1:0] w_s1 [3];
	logic signed [DW-1:0] d_s1 [3];
	logic signed [DW-1:0] v_vec_s1 [3];
	logic                 root_s1, root_s2, root_s3;

	logic signed [2*DW-1:0] wsq_p [3];
	logic signed [2*DW-1:0] dsq_p [3];
	logic signed [2*DW-1:0] vsq_p [3];
	logic signed [2*DW-1:0] wd_p [3];

	logic [SQW-1:0]         wsq_s2 [3];
	logic [SQW-1:0]         dsq_s2 [3];
	logic [SQW-1:0]         vsq_s2 [3];
	logic signed [2*DW-1:0] wd_s2 [3];

	logic [KW-1:0]        ww_s3, ll_s3, vv_s3;
	logic signed [KW:0]   ss_s3;

	assign p[0] = point_x;
	assign p[1] = point_y;
	assign p[2] = point_z;
	assign b[0] = base_x;
	assign b[1] = base_y;
	assign b[2] = base_z;
	assign t[0] = tip_x;
	assign t[1] = tip_y;
	assign t[2] = tip_z;

	assign adv_s3 = !v_s3 || out_ready;
	assign adv_s2 = !v_s2 || adv_s3;
	assign adv_s1 = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wsq_p[i] = w_s1[i] * w_s1[i];
			dsq_p[i] = d_s1[i] * d_s1[i];
			vsq_p[i] = v_vec_s1[i] * v_vec_s1[i];
			wd_p[i]  = w_s1[i] * d_s1[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			for (int i = 0; i < 3; i++) begin
				w_s1[i]     <= {p[i][COORD_WIDTH-1], p[i]} - {b[i][COORD_WIDTH-1], b[i]};
				d_s1[i]     <= {t[i][COORD_WIDTH-1], t[i]} - {b[i][COORD_WIDTH-1], b[i]};
				v_vec_s1[i] <= {p[i][COORD_WIDTH-1], p[i]} - {t[i][COORD_WIDTH-1], t[i]};
			end
			root_s1 <= is_root;
		end
		if (adv_s2) begin
			for (int i = 0; i < 3; i++) begin
				wsq_s2[i] <= wsq_p[i][SQW-1:0];
				dsq_s2[i] <= dsq_p[i][SQW-1:0];
				vsq_s2[i] <= vsq_p[i][SQW-1:0];
				wd_s2[i]  <= wd_p[i];
			end
			root_s2 <= root_s1;
		end
		if (adv_s3) begin
			ww_s3   <= KW'(wsq_s2[0]) + KW'(wsq_s2[1]) + KW'(wsq_s2[2]);
			ll_s3   <= KW'(dsq_s2[0]) + KW'(dsq_s2[1]) + KW'(dsq_s2[2]);
			vv_s3   <= KW'(vsq_s2[0]) + KW'(vsq_s2[1]) + KW'(vsq_s2[2]);
			ss_s3   <= (KW+1)'(wd_s2[0]) + (KW+1)'(wd_s2[1]) + (KW+1)'(wd_s2[2]);
			root_s3 <= root_s2;
		end
	end

	assign out_valid = v_s3;
	assign ww = ww_s3;
	assign ll = ll_s3;
	assign vv = vv_s3;
	assign ss = ss_s3;
	assign root = root_s3;

endmodule

@@ rtl/pcc_classify.sv @@
// ----------------------------------------------------------------------------
// pcc_classify
// One pipeline stage that picks the closest-point case, settles the end and
// near cases, and prepares the operands of the interior comparison.
// ----------------------------------------------------------------------------
module pcc_classify
	import pcc_pkg::*;
#(
	parameter int COORD_WIDTH = PCC_COORD_W
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [2*COORD_WIDTH+1:0]        ww,
	input  logic [2*COORD_WIDTH+1:0]        ll,
	input  logic [2*COORD_WIDTH+1:0]        vv,
	input  logic signed [2*COORD_WIDTH+2:0] ss,
	input  logic                            root,
	input  logic [2*COORD_WIDTH-3:0]        radius_sq,
	output logic                            out_valid,
	input  logic                            out_ready,
	output pcc_class_t                      cls,
	output logic [2*COORD_WIDTH+1:0]        excess,
	output logic [2*COORD_WIDTH+1:0]        len_sq,
	output logic [2*COORD_WIDTH+1:0]        proj
);

	localparam int KW = 2 * COORD_WIDTH + 2;

	logic          v_s4, adv_s4;
	logic [KW-1:0] r2x;
	logic          base_case, tip_case, ww_le, vv_le;
	pcc_class_t    cls_d, cls_s4;
	logic [KW-1:0] excess_s4, len_sq_s4, proj_s4;

	assign adv_s4 = !v_s4 || out_ready;
	assign in_ready = adv_s4;

	always_comb begin
		r2x       = KW'(radius_sq);
		base_case = (ll == '0) || ss[KW] || (ss == '0);
		tip_case  = ss[KW-1:0] >= ll;
		ww_le     = ww <= r2x;
		vv_le     = vv <= r2x;
		cls_d.decided = base_case || tip_case || ww_le;
		if (base_case) begin
			cls_d.early_inside = ww_le;
		end else if (tip_case) begin
			cls_d.early_inside = vv_le;
		end else begin
			cls_d.early_inside = 1'b1;
		end
		cls_d.is_root = root;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv_s4) begin
			v_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			cls_s4    <= cls_d;
			excess_s4 <= ww - r2x;
			len_sq_s4 <= ll;
			// Only used in the interior case, where 0 < s < L.
			proj_s4   <= ss[KW-1:0];
		end
	end

	assign out_valid = v_s4;
	assign cls = cls_s4;
	assign excess = excess_s4;
	assign len_sq = len_sq_s4;
	assign proj = proj_s4;

endmodule

@@ rtl/pcc_wide_cmp.sv @@
// ----------------------------------------------------------------------------
// pcc_wide_cmp
// Compares (|w|^2 - r^2) * L against s^2 over half-width partial products,
// then registers the result item.
// ----------------------------------------------------------------------------
module pcc_wide_cmp
	import pcc_pkg::*;
#(
	parameter int COORD_WIDTH = PCC_COORD_W
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  pcc_class_t               cls,
	input  logic [2*COORD_WIDTH+1:0] excess,
	input  logic [2*COORD_WIDTH+1:0] len_sq,
	input  logic [2*COORD_WIDTH+1:0] proj,
	output logic                     out_valid,
	input  logic                     out_stall,
	output pcc_out_t                 result
);

	localparam int HW = COORD_WIDTH + 1; // half of an operand
	localparam int PW = 2 * HW;          // partial product width
	localparam int LW = 4 * HW;          // full product width

	logic v_s5, v_s6, v_s7;
	logic adv_s5, adv_s6, adv_s7;

	logic [HW-1:0] eh, el, lh, lo, sh, sl;
	logic [PW-1:0] e_hh_s5, e_hl_s5, e_lh_s5, e_ll_s5;
	logic [PW-1:0] s_hh_s5, s_hl_s5, s_ll_s5;
	pcc_class_t    cls_s5, cls_s6;
	logic [LW-1:0] lhs_s6, rhs_s6;
	pcc_out_t      result_s7;
	logic          in_capsule;

	assign adv_s7 = !v_s7 || !out_stall;
	assign adv_s6 = !v_s6 || adv_s7;
	assign adv_s5 = !v_s5 || adv_s6;
	assign in_ready = adv_s5;

	assign {eh, el} = excess;
	assign {lh, lo} = len_sq;
	assign {sh, sl} = proj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (adv_s5) v_s5 <= in_valid;
			if (adv_s6) v_s6 <= v_s5;
			if (adv_s7) v_s7 <= v_s6;
		end
	end

	always_comb begin
		in_capsule = cls_s6.decided ? cls_s6.early_inside : (lhs_s6 <= rhs_s6);
	end

	always_ff @(posedge clk) begin
		if (adv_s5) begin
			e_hh_s5 <= PW'(eh) * PW'(lh);
			e_hl_s5 <= PW'(eh) * PW'(lo);
			e_lh_s5 <= PW'(el) * PW'(lh);
			e_ll_s5 <= PW'(el) * PW'(lo);
			s_hh_s5 <= PW'(sh) * PW'(sh);
			s_hl_s5 <= PW'(sh) * PW'(sl);
			s_ll_s5 <= PW'(sl) * PW'(sl);
			cls_s5  <= cls;
		end
		if (adv_s6) begin
			lhs_s6 <= {e_hh_s5, e_ll_s5} + ((LW'(e_hl_s5) + LW'(e_lh_s5)) << HW);
			rhs_s6 <= {s_hh_s5, s_ll_s5} + (LW'(s_hl_s5) << (HW + 1));
			cls_s6 <= cls_s5;
		end
		if (adv_s7) begin
			result_s7.inside_res <= in_capsule;
			result_s7.stop_point <= in_capsule && !cls_s6.is_root;
		end
	end

	assign out_valid = v_s7;
	assign result = result_s7;

endmodule

@@ rtl/point_capsule_collision_test.sv @@
// ----------------------------------------------------------------------------
// point_capsule_collision_test
// Throughput: one item per cycle; the seven-stage pipeline stalls only when
// result_stall holds a waiting result and every stage behind it is full.
// Reset clears the stage valid bits and all configuration registers to zero.
// ----------------------------------------------------------------------------
module point_capsule_collision_test
	import pcc_pkg::*;
#(
	parameter int COORD_WIDTH = PCC_COORD_W
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// Point items in.
	input  logic                     point_valid,
	output logic                     point_stall,
	input  pcc_in_t                  point,
	// Result items out.
	output logic                     result_valid,
	input  logic                     result_stall,
	output pcc_out_t                 result,
	// Configuration writes.
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [PCC_CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_WIDTH-1:0]   cfg_data
);

	localparam int KW = 2 * COORD_WIDTH + 2;
	localparam int R2W = 2 * (COORD_WIDTH - 1);

	// Capsule geometry. The radius square is registered from the radius so
	// that no multiplier sits in front of the compare stage; it settles in the
	// cycle after a write, well before any item reaches the compare stage.
	logic signed [COORD_WIDTH-1:0] base_x_q, base_y_q, base_z_q;
	logic signed [COORD_WIDTH-1:0] tip_x_q, tip_y_q, tip_z_q;
	logic [COORD_WIDTH-2:0]        radius_q;
	logic [R2W-1:0]                radius_sq_q;

	// Links between the pipeline sections.
	logic                dots_ready, dots_valid;
	logic [KW-1:0]       ww, ll, vv;
	logic signed [KW:0]  ss;
	logic                dots_root;
	logic                cls_ready, cls_valid;
	pcc_class_t          cls;
	logic [KW-1:0]       excess, len_sq, proj;
	logic                cmp_ready;

	// The configuration port never pushes back.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_x_q    <= '0;
			base_y_q    <= '0;
			base_z_q    <= '0;
			tip_x_q     <= '0;
			tip_y_q     <= '0;
			tip_z_q     <= '0;
			radius_q    <= '0;
			radius_sq_q <= '0;
		end else begin
			radius_sq_q <= R2W'(radius_q) * R2W'(radius_q);
			if (cfg_valid && cfg_ready) begin
				case (pcc_reg_t'(cfg_index))
					PCC_REG_BASE_X: base_x_q <= cfg_data;
					PCC_REG_BASE_Y: base_y_q <= cfg_data;
					PCC_REG_BASE_Z: base_z_q <= cfg_data;
					PCC_REG_TIP_X:  tip_x_q  <= cfg_data;
					PCC_REG_TIP_Y:  tip_y_q  <= cfg_data;
					PCC_REG_TIP_Z:  tip_z_q  <= cfg_data;
					PCC_REG_RADIUS: radius_q <= cfg_data[COORD_WIDTH-2:0];
					default: begin
						// Writes to unused indexes are dropped.
					end
				endcase
			end
		end
	end

	// Each section hands its ready back up the chain, so a bubble anywhere
	// in the pipeline lets the stages behind it move on even while the
	// output register holds a result that has not been taken.
	assign point_stall = !dots_ready;

	// Stages one to three: differences, products and dot-product sums.
	pcc_dots #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_dots (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (point_valid),
		.in_ready (dots_ready),
		.point_x  (COORD_WIDTH'(point.point_x)),
		.point_y  (COORD_WIDTH'(point.point_y)),
		.point_z  (COORD_WIDTH'(point.point_z)),
		.is_root  (point.is_root),
		.base_x   (base_x_q),
		.base_y   (base_y_q),
		.base_z   (base_z_q),
		.tip_x    (tip_x_q),
		.tip_y    (tip_y_q),
		.tip_z    (tip_z_q),
		.out_valid(dots_valid),
		.out_ready(cls_ready),
		.ww       (ww),
		.ll       (ll),
		.vv       (vv),
		.ss       (ss),
		.root     (dots_root)
	);

	// Stage four: the base end covers a zero-length segment and a point at
	// or behind the base; the tip end covers a point at or past the tip; a
	// point within the radius of the base is inside unless it is past the tip.
	pcc_classify #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_classify (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (dots_valid),
		.in_ready (cls_ready),
		.ww       (ww),
		.ll       (ll),
		.vv       (vv),
		.ss       (ss),
		.root     (dots_root),
		.radius_sq(radius_sq_q),
		.out_valid(cls_valid),
		.out_ready(cmp_ready),
		.cls      (cls),
		.excess   (excess),
		.len_sq   (len_sq),
		.proj     (proj)
	);

	// Stages five to seven: the division-free interior test, with the wide
	// products split into half-width partial products, and the output
	// register.
	pcc_wide_cmp #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_wide_cmp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cls_valid),
		.in_ready (cmp_ready),
		.cls      (cls),
		.excess   (excess),
		.len_sq   (len_sq),
		.proj     (proj),
		.out_valid(result_valid),
		.out_stall(result_stall),
		.result   (result)
	);

	// A point is only ever stopped when it is inside.
	a_stop_needs_inside: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.stop_point |-> result.inside_res)
		else $error("stop_point raised without inside_res");

	// Input back-pressure can only come from a result that waits to be taken.
	a_stall_from_output: assert property (@(posedge clk) disable iff (!arst_n)
		point_stall |-> result_valid && result_stall)
		else $error("point_stall raised while the output side can move");

endmodule
